// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the sound lump converter.
// Simulation gets concurrent assertions; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PCM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

`define PCM_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define PCM_ASSERT_IMPLY(label, clk, rst, ante, cons)

`define PCM_ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

// ----- rtl/pcm2s_pkg.sv -----
// Types and constants of the 8-bit sound lump to 16-bit stereo converter.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package pcm2s_pkg;

   localparam int unsigned OutRate   = 44100;
   localparam int unsigned MaxFrames = 45;

   // Ceiling of 2^44 / 11025. For every 16-bit rate, (rate * RATE_RECIP) >> 30
   // equals (rate << 16) / 44100 exactly.
   localparam logic [30:0] RATE_RECIP = 31'd1595663134;

   localparam logic [15:0] RATE_FULL    = 16'd44100;
   localparam logic [15:0] RATE_HALF    = 16'd22050;
   localparam logic [15:0] RATE_QUARTER = 16'd11025;
   localparam logic [15:0] RATE_MIN     = 16'd1000;
   localparam logic [15:0] VERSION_OK   = 16'd3;
   localparam logic [7:0]  SIGN_FLIP    = 8'h80;
   localparam logic [17:0] PHASE_ONE    = 18'h10000;

   typedef enum logic [1:0] {
      STATUS_FRAME       = 2'd0,
      STATUS_BAD_VERSION = 2'd1,
      STATUS_BAD_RATE    = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] lump_byte;
      logic       lump_start;
   } req_type;

   typedef struct packed {
      logic signed [15:0] frame_sample;
      status_type         status;
      logic               last_of_run;
      logic               end_of_sound;
   } rsp_type;

   typedef enum logic [3:0] {
      LUMP_IDLE    = 4'b0001,
      LUMP_HEADER  = 4'b0010,
      LUMP_SAMPLES = 4'b0100,
      LUMP_STOPPED = 4'b1000
   } lump_mode_type;

   typedef enum logic [2:0] {
      SEQ_READY  = 3'b001,
      SEQ_DIVIDE = 3'b010,
      SEQ_EMIT   = 3'b100
   } seq_state_type;

endpackage

// ----- rtl/pcm8_to_stereo16_resampler.sv -----
// Top level of the 8-bit sound lump to 16-bit stereo frame converter.
// Depends on pcm2s_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Takes a sound lump one byte per item: an 8-byte little-endian header
// (version, source rate, sample count), then offset 8-bit samples, each sent
// as signed 16-bit stereo frames at 44100 Hz. After a valid upper rate byte
// the block passes through its divide state, where the 1.16 phase step is
// found by multiplying the rate with a fixed reciprocal of 44100.
// A sample that gives frames is accepted in the ready state; its frames then
// leave one after another from the emit state through the output register.
// A sample that gives no frame is only accepted. Error results (bad version,
// unsupported rate) are single items. No byte is taken in the divide or emit
// state, and output back-pressure holds the emit state.
module pcm8_to_stereo16_resampler
   import pcm2s_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [5:0]  EmitLast  = 6'(MaxFrames - 1);

   seq_state_type seq_ff, seq_in;
   lump_mode_type lump_ff, lump_in;
   logic [2:0]  hdr_pos_ff, hdr_pos_in;
   logic [7:0]  ver_low_ff, ver_low_in;
   logic [15:0] rate_ff, rate_in;
   logic [31:0] samples_ff, samples_in;
   logic [16:0] step_ff, step_in;
   logic [17:0] acc_ff, acc_in;
   logic [15:0] emit_sample_ff, emit_sample_in;
   status_type  emit_status_ff, emit_status_in;
   logic        emit_eos_ff, emit_eos_in;
   logic        emit_phase_ff, emit_phase_in;
   logic [2:0]  emit_reps_ff, emit_reps_in;
   logic [5:0]  emit_cnt_ff, emit_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic          req_accept;
   logic          out_free;
   lump_mode_type mode_eff;
   logic [2:0]    pos_eff;
   logic [7:0]    b;
   logic [31:0]   samples_dec;
   logic          eos;
   logic [46:0]   recip_prod;
   logic [17:0]   next_acc;
   logic          last;
   logic          rsp_error;
   logic          error_shape_ok;

   assign req_ready  = (seq_ff == SEQ_READY);
   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      seq_in         = seq_ff;
      lump_in        = lump_ff;
      hdr_pos_in     = hdr_pos_ff;
      ver_low_in     = ver_low_ff;
      rate_in        = rate_ff;
      samples_in     = samples_ff;
      step_in        = step_ff;
      acc_in         = acc_ff;
      emit_sample_in = emit_sample_ff;
      emit_status_in = emit_status_ff;
      emit_eos_in    = emit_eos_ff;
      emit_phase_in  = emit_phase_ff;
      emit_reps_in   = emit_reps_ff;
      emit_cnt_in    = emit_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_data_in    = rsp_data_ff;

      b           = req_data.lump_byte;
      mode_eff    = req_data.lump_start ? LUMP_HEADER : lump_ff;
      pos_eff     = req_data.lump_start ? 3'd0 : hdr_pos_ff;
      samples_dec = samples_ff - 32'd1;
      eos         = (samples_dec == 32'd0);
      recip_prod  = 47'(rate_ff) * 47'(RATE_RECIP);
      next_acc    = acc_ff + {1'b0, step_ff};
      last        = 1'b0;

      unique case (seq_ff)
         SEQ_READY: begin
            if (req_accept) begin
               if (req_data.lump_start) begin
                  lump_in = LUMP_HEADER;
                  acc_in  = '0;
               end
               unique case (mode_eff)
                  LUMP_HEADER: begin
                     hdr_pos_in = pos_eff + 3'd1;
                     unique case (pos_eff)
                        3'd0: ver_low_in = b;
                        3'd1: begin
                           if ({b, ver_low_ff} != VERSION_OK) begin
                              lump_in        = LUMP_STOPPED;
                              seq_in         = SEQ_EMIT;
                              emit_sample_in = '0;
                              emit_status_in = STATUS_BAD_VERSION;
                              emit_eos_in    = 1'b0;
                              emit_phase_in  = 1'b0;
                              emit_reps_in   = 3'd1;
                              emit_cnt_in    = '0;
                           end
                        end
                        3'd2: rate_in = {8'h00, b};
                        3'd3: begin
                           rate_in = {b, rate_ff[7:0]};
                           if ({b, rate_ff[7:0]} < RATE_MIN) begin
                              lump_in        = LUMP_STOPPED;
                              seq_in         = SEQ_EMIT;
                              emit_sample_in = '0;
                              emit_status_in = STATUS_BAD_RATE;
                              emit_eos_in    = 1'b0;
                              emit_phase_in  = 1'b0;
                              emit_reps_in   = 3'd1;
                              emit_cnt_in    = '0;
                           end else begin
                              // The phase step is formed next cycle from the
                              // registered rate.
                              seq_in = SEQ_DIVIDE;
                           end
                        end
                        default: begin
                           samples_in[{pos_eff[1:0], 3'b000} +: 8] = b;
                           if (pos_eff == 3'd7) begin
                              lump_in = (samples_in != 32'd0) ? LUMP_SAMPLES
                                                              : LUMP_STOPPED;
                              acc_in  = '0;
                           end
                        end
                     endcase
                  end
                  LUMP_SAMPLES: begin
                     samples_in     = samples_dec;
                     if (eos) begin
                        lump_in = LUMP_STOPPED;
                     end
                     emit_sample_in = {b ^ SIGN_FLIP, 8'h00};
                     emit_status_in = STATUS_FRAME;
                     emit_eos_in    = eos;
                     emit_cnt_in    = '0;
                     if (rate_ff == RATE_FULL || rate_ff == RATE_HALF ||
                         rate_ff == RATE_QUARTER) begin
                        seq_in        = SEQ_EMIT;
                        emit_phase_in = 1'b0;
                        emit_reps_in  = (rate_ff == RATE_FULL) ? 3'd1 :
                                        (rate_ff == RATE_HALF) ? 3'd2 : 3'd4;
                     end else if (acc_ff[17:16] != 2'b00) begin
                        // Source faster than output: this sample is skipped.
                        acc_in = acc_ff - PHASE_ONE;
                     end else begin
                        seq_in        = SEQ_EMIT;
                        emit_phase_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         SEQ_DIVIDE: begin
            // Rate times 65536 over 44100, rounded down, plus one, by reciprocal multiplication.
            step_in = recip_prod[46:30] + 17'd1;
            seq_in  = SEQ_READY;
         end
         SEQ_EMIT: begin
            if (out_free) begin
               if (emit_phase_ff) begin
                  last   = (next_acc[17:16] != 2'b00) || (emit_cnt_ff == EmitLast);
                  acc_in = last ? next_acc - PHASE_ONE : next_acc;
               end else begin
                  last = ((emit_cnt_ff[2:0] + 3'd1) == emit_reps_ff);
               end
               rsp_valid_in             = 1'b1;
               rsp_data_in.frame_sample = emit_sample_ff;
               rsp_data_in.status       = emit_status_ff;
               rsp_data_in.last_of_run  = last;
               rsp_data_in.end_of_sound = emit_eos_ff;
               emit_cnt_in              = emit_cnt_ff + 6'd1;
               if (last) begin
                  seq_in = SEQ_READY;
               end
            end
         end
         default: seq_in = SEQ_READY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SEQ_READY;
         lump_ff      <= LUMP_IDLE;
         hdr_pos_ff   <= '0;
         rate_ff      <= '0;
         samples_ff   <= '0;
         step_ff      <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         lump_ff      <= lump_in;
         hdr_pos_ff   <= hdr_pos_in;
         rate_ff      <= rate_in;
         samples_ff   <= samples_in;
         step_ff      <= step_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ver_low_ff     <= ver_low_in;
      emit_sample_ff <= emit_sample_in;
      emit_status_ff <= emit_status_in;
      emit_eos_ff    <= emit_eos_in;
      emit_phase_ff  <= emit_phase_in;
      emit_reps_ff   <= emit_reps_in;
      emit_cnt_ff    <= emit_cnt_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Error items are single, carry no sample and never mark end of sound.
   assign rsp_error      = rsp_valid_ff && (rsp_data_ff.status != STATUS_FRAME);
   assign error_shape_ok = rsp_data_ff.last_of_run && (rsp_data_ff.frame_sample == 16'sd0) &&
                           !rsp_data_ff.end_of_sound;

   `PCM_ASSERT_IMPLY(a_error_shape, clock, reset, rsp_error, error_shape_ok)
   `PCM_ASSERT_NEVER(a_emit_bound, clock, reset, seq_ff == SEQ_EMIT && emit_cnt_ff > EmitLast)
   `PCM_ASSERT_IMPLY(a_divide_ctx, clock, reset, seq_ff == SEQ_DIVIDE, lump_ff == LUMP_HEADER && hdr_pos_ff == 3'd4)

endmodule
